// ===== sv/mae_pkg.sv =====
`timescale 1ns / 1ps
package mae_pkg;

  localparam int unsigned DIM_W = 5;
  localparam int unsigned RC_W = 3;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_SCALE = 3'd2,
    MODE_MUL = 3'd3,
    MODE_TRN = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REG_OP_MODE = 3'd0,
    REG_ROWS_A = 3'd1,
    REG_COLS_A = 3'd2,
    REG_COLS_B = 3'd3,
    REG_SCALE = 3'd4
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ADDR = 5'b00010,
    ST_MUL = 5'b00100,
    ST_ACC = 5'b01000,
    ST_EMIT = 5'b10000
  } back_state_e;

  typedef struct packed {
    logic req_type;
    logic signed [31:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0] result_row;
    logic [2:0] result_col;
    logic overflow;
    logic last_result;
  } out_item_t;

  typedef struct packed {
    logic [2:0] op_mode;
    logic [3:0] rows_a;
    logic [3:0] cols_a;
    logic [3:0] cols_b;
    logic signed [31:0] scale_factor;
  } cfg_t;

  typedef struct packed {
    mode_e mode;
    logic [DIM_W-1:0] orows;
    logic [DIM_W-1:0] ocols;
    logic [DIM_W-1:0] cols_a;
    logic [DIM_W-1:0] cols_b;
    logic signed [31:0] scale;
  } job_t;

  typedef struct packed {
    logic we_a;
    logic we_b;
    logic signed [31:0] data;
  } mem_wr_t;

  function automatic mode_e eff_mode(input logic [2:0] m);
    mode_e r;
    case (m)
      3'd0: r = MODE_ADD;
      3'd1: r = MODE_SUB;
      3'd2: r = MODE_SCALE;
      3'd3: r = MODE_MUL;
      default: r = MODE_TRN;
    endcase
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [3:0] d,
                                                 input logic [DIM_W-1:0] mx);
    logic [DIM_W-1:0] r;
    r = DIM_W'(d);
    if (d == 4'd0) r = DIM_W'(1);
    else if (r > mx) r = mx;
    return r;
  endfunction

endpackage

// ===== sv/mae_jobq.sv =====
`timescale 1ns / 1ps
module mae_jobq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mae_pkg::job_t    job_i,
  input  logic             pop_i,
  output logic             empty_o,
  output mae_pkg::job_t    job_o
);
  import mae_pkg::*;

  job_t slot_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i && cnt_q != 2'd2) slot_q[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && cnt_q != 2'd2) wp_q <= ~wp_q;
      if (pop_i && cnt_q != 2'd0) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i && cnt_q != 2'd2) - 2'(pop_i && cnt_q != 2'd0);
    end
  end

  assign empty_o = (cnt_q == 2'd0);
  assign job_o = slot_q[rp_q];

endmodule

// ===== sv/mae_front.sv =====
`timescale 1ns / 1ps
module mae_front #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  mae_pkg::in_item_t     in_item_i,
  input  mae_pkg::cfg_t         cfg_i,
  input  logic                  busy_i,
  input  logic                  jq_empty_i,
  output logic                  jq_push_o,
  output mae_pkg::job_t         job_o,
  output mae_pkg::mem_wr_t      wr_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr_o
);
  import mae_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [DIM_W-1:0] MaxD = DIM_W'(MAX_DIM);

  logic [CW-1:0] fcnt_q, fcnt_d, scnt_q, scnt_d, asz, bsz;
  logic [DIM_W-1:0] r, c, cb;
  mode_e mode;
  logic accept, a_load, b_load, trigger;

  assign mode = eff_mode(cfg_i.op_mode);
  assign r = clamp_dim(cfg_i.rows_a, MaxD);
  assign c = clamp_dim(cfg_i.cols_a, MaxD);
  assign cb = clamp_dim(cfg_i.cols_b, MaxD);
  assign asz = CW'(r) * CW'(c);

  always_comb begin
    case (mode)
      MODE_ADD, MODE_SUB: bsz = CW'(r) * CW'(c);
      MODE_MUL: bsz = CW'(c) * CW'(cb);
      default: bsz = '0;
    endcase
  end

  // Operand stores must not change while the back end still reads them.
  assign full = busy_i | ~jq_empty_i;
  assign accept = push & ~full;
  assign a_load = accept && !in_item_i.req_type && fcnt_q < asz;
  assign b_load = accept && in_item_i.req_type && scnt_q < bsz;

  assign wr_o.we_a = a_load;
  assign wr_o.we_b = b_load;
  assign wr_o.data = in_item_i.element_value;
  assign wr_addr_o = a_load ? AW'(fcnt_q) : AW'(scnt_q);

  always_comb begin
    fcnt_d = fcnt_q + CW'(a_load);
    scnt_d = scnt_q + CW'(b_load);
    trigger = accept && fcnt_d >= asz && scnt_d >= bsz;
    if (trigger) begin
      fcnt_d = '0;
      scnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= '0;
      scnt_q <= '0;
    end else begin
      fcnt_q <= fcnt_d;
      scnt_q <= scnt_d;
    end
  end

  assign jq_push_o = trigger;
  always_comb begin
    job_o.mode = mode;
    job_o.orows = r;
    job_o.ocols = c;
    if (mode == MODE_MUL) job_o.ocols = cb;
    if (mode == MODE_TRN) begin
      job_o.orows = c;
      job_o.ocols = r;
    end
    job_o.cols_a = c;
    job_o.cols_b = cb;
    job_o.scale = cfg_i.scale_factor;
  end

`ifndef SYNTHESIS
  a_trig_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trigger |=> fcnt_q == '0 && scnt_q == '0)
    else $error("counts not cleared after job start");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_load |=> fcnt_q <= CW'(DEPTH))
    else $error("first count beyond store depth");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_i |-> !a_load && !b_load)
    else $error("store written while job runs");
`endif

endmodule

// ===== sv/mae_back.sv =====
`timescale 1ns / 1ps
module mae_back #(
  parameter int unsigned MAX_DIM = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  jq_empty_i,
  input  mae_pkg::job_t         job_i,
  output logic                  jq_pop_o,
  input  mae_pkg::mem_wr_t      wr_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr_i,
  output logic                  busy_o,
  output logic                  empty,
  input  logic                  pop,
  output mae_pkg::out_item_t    out_item_o
);
  import mae_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = 2 * DIM_W + 1;

  logic signed [31:0] mem_a [DEPTH];
  logic signed [31:0] mem_b [DEPTH];
  logic signed [31:0] rd_a_q, rd_b_q;

  back_state_e state_q, state_d;
  job_t job_q;
  logic [DIM_W-1:0] i_q, j_q, k_q, kmax;
  logic [PW-1:0] a_lin, b_lin;
  logic signed [63:0] prod_q, sum_q, acc_q, term;
  logic out_valid_q, slot_free, emit, last_el;
  out_item_t out_q;

  assign kmax = (job_q.mode == MODE_MUL) ? job_q.cols_a : DIM_W'(1);
  assign last_el = (i_q + DIM_W'(1) == job_q.orows) && (j_q + DIM_W'(1) == job_q.ocols);

  always_comb begin
    case (job_q.mode)
      MODE_MUL: begin
        a_lin = PW'(i_q) * PW'(job_q.cols_a) + PW'(k_q);
        b_lin = PW'(k_q) * PW'(job_q.cols_b) + PW'(j_q);
      end
      MODE_TRN: begin
        a_lin = PW'(j_q) * PW'(job_q.cols_a) + PW'(i_q);
        b_lin = a_lin;
      end
      default: begin
        a_lin = PW'(i_q) * PW'(job_q.cols_a) + PW'(j_q);
        b_lin = a_lin;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we_a) mem_a[wr_addr_i] <= wr_i.data;
    if (wr_i.we_b) mem_b[wr_addr_i] <= wr_i.data;
    if (state_q == ST_ADDR) begin
      rd_a_q <= mem_a[AW'(a_lin)];
      rd_b_q <= mem_b[AW'(b_lin)];
    end
  end

  // Products are floored by the arithmetic shift; other modes pass the sum.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= 64'(rd_a_q) * ((job_q.mode == MODE_SCALE) ? 64'(job_q.scale)
                                                         : 64'(rd_b_q));
      case (job_q.mode)
        MODE_ADD: sum_q <= 64'(rd_a_q) + 64'(rd_b_q);
        MODE_SUB: sum_q <= 64'(rd_a_q) - 64'(rd_b_q);
        default: sum_q <= 64'(rd_a_q);
      endcase
    end
    if (state_q == ST_ACC) acc_q <= ((k_q == '0) ? 64'sd0 : acc_q) + term;
  end

  assign term = (job_q.mode == MODE_MUL || job_q.mode == MODE_SCALE)
                ? (prod_q >>> FRAC_BITS) : sum_q;

  assign slot_free = !out_valid_q || pop;
  assign emit = (state_q == ST_EMIT) && slot_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (!jq_empty_i) state_d = ST_ADDR;
      ST_ADDR: state_d = ST_MUL;
      ST_MUL: state_d = ST_ACC;
      ST_ACC: state_d = (k_q + DIM_W'(1) < kmax) ? ST_ADDR : ST_EMIT;
      ST_EMIT: if (slot_free) state_d = last_el ? ST_IDLE : ST_ADDR;
      default: state_d = ST_IDLE;
    endcase
  end

  assign jq_pop_o = (state_q == ST_IDLE) && !jq_empty_i;
  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (jq_pop_o) job_q <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (jq_pop_o) begin
        i_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end
      if (state_q == ST_ACC && state_d == ST_ADDR) k_q <= k_q + DIM_W'(1);
      if (emit) begin
        k_q <= '0;
        if (j_q + DIM_W'(1) == job_q.ocols) begin
          j_q <= '0;
          i_q <= i_q + DIM_W'(1);
        end else begin
          j_q <= j_q + DIM_W'(1);
        end
      end
      if (emit) out_valid_q <= 1'b1;
      else if (pop) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (acc_q > 64'sd2147483647) begin
        out_q.result_value <= 32'sh7FFFFFFF;
        out_q.overflow <= 1'b1;
      end else if (acc_q < -64'sd2147483648) begin
        out_q.result_value <= 32'sh80000000;
        out_q.overflow <= 1'b1;
      end else begin
        out_q.result_value <= 32'(acc_q);
        out_q.overflow <= 1'b0;
      end
      out_q.result_row <= RC_W'(i_q);
      out_q.result_col <= RC_W'(j_q);
      out_q.last_result <= last_el;
    end
  end

  assign empty = !out_valid_q;
  assign out_item_o = out_q;

`ifndef SYNTHESIS
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_el) |=> state_q == ST_IDLE)
    else $error("job did not end after last element");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> k_q < kmax)
    else $error("inner index out of range");
  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> $stable(out_q))
    else $error("waiting result overwritten");
`endif

endmodule

// ===== sv/matrix_arithmetic_engine.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// input     in         push / full             in_item_i (req_type, element_value)
// result    out        empty / pop             out_item_o (value, row, col, flags)
// config    in/out     psel penable pwrite     paddr, pwdata, prdata (5 registers)
// The job is started by the load that fills the operands. Each result element passes
// through the read, multiply and accumulate states once per inner-product step, then
// the emit state; products come from the single shared multiplier. Input reports full
// while a job is queued or runs; the back end stalls only when a result waits.
// Reset is asynchronous and active low; the operand stores need no clearing.
module matrix_arithmetic_engine #(
  parameter int unsigned MAX_DIM = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  mae_pkg::in_item_t     in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output mae_pkg::out_item_t    out_item_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import mae_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DIM * MAX_DIM);

  cfg_t cfg_q;
  job_t job_f, job_b;
  mem_wr_t wr;
  logic [AW-1:0] wr_addr;
  logic jq_push, jq_pop, jq_empty, busy;
  reg_idx_e ridx;

  assign pready = 1'b1;
  assign ridx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.op_mode <= 3'd3;
      cfg_q.rows_a <= 4'd8;
      cfg_q.cols_a <= 4'd8;
      cfg_q.cols_b <= 4'd8;
      cfg_q.scale_factor <= 32'sd65536;
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        REG_OP_MODE: cfg_q.op_mode <= pwdata[2:0];
        REG_ROWS_A: cfg_q.rows_a <= pwdata[3:0];
        REG_COLS_A: cfg_q.cols_a <= pwdata[3:0];
        REG_COLS_B: cfg_q.cols_b <= pwdata[3:0];
        REG_SCALE: cfg_q.scale_factor <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_OP_MODE: prdata = 32'(cfg_q.op_mode);
      REG_ROWS_A: prdata = 32'(cfg_q.rows_a);
      REG_COLS_A: prdata = 32'(cfg_q.cols_a);
      REG_COLS_B: prdata = 32'(cfg_q.cols_b);
      REG_SCALE: prdata = cfg_q.scale_factor;
      default: prdata = '0;
    endcase
  end

  mae_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i, .rst_ni, .push, .full, .in_item_i,
    .cfg_i(cfg_q), .busy_i(busy), .jq_empty_i(jq_empty),
    .jq_push_o(jq_push), .job_o(job_f), .wr_o(wr), .wr_addr_o(wr_addr)
  );

  mae_jobq u_jobq (
    .clk_i, .rst_ni, .push_i(jq_push), .job_i(job_f),
    .pop_i(jq_pop), .empty_o(jq_empty), .job_o(job_b)
  );

  mae_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .jq_empty_i(jq_empty), .job_i(job_b), .jq_pop_o(jq_pop),
    .wr_i(wr), .wr_addr_i(wr_addr), .busy_o(busy),
    .empty, .pop, .out_item_o
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import mae_pkg::*;

  class matrix_scoreboard;
    logic signed [31:0] mat_a[64];
    logic signed [31:0] mat_b[64];
    int unsigned cnt_a, cnt_b;
    logic [2:0] mode_r;
    logic [3:0] rows_r, cols_r, colsb_r;
    logic signed [31:0] scale_r;
    out_item_t pending[$];
    int errors;

    function new();
      mode_r = MODE_MUL;
      rows_r = 4'd8;
      cols_r = 4'd8;
      colsb_r = 4'd8;
      scale_r = 32'sd65536;
      cnt_a = 0;
      cnt_b = 0;
      errors = 0;
    endfunction

    function int unsigned dim(logic [3:0] d);
      if (d == 0) return 1;
      if (d > 8) return 8;
      return d;
    endfunction

    function logic signed [63:0] fix_mul(logic signed [31:0] x, logic signed [31:0] y);
      logic signed [63:0] p;
      p = 64'(x) * 64'(y);
      return p >>> 16;
    endfunction

    function void note_load(in_item_t it);
      mode_e m;
      int unsigned r, c, cb, asz, bsz, orow, ocol;
      logic signed [63:0] acc;
      out_item_t o;
      m = eff_mode(mode_r);
      r = dim(rows_r);
      c = dim(cols_r);
      cb = dim(colsb_r);
      asz = r * c;
      bsz = (m == MODE_ADD || m == MODE_SUB) ? r * c : (m == MODE_MUL) ? c * cb : 0;
      if (it.req_type == 1'b0) begin
        if (cnt_a < asz) begin
          mat_a[cnt_a] = it.element_value;
          cnt_a++;
        end
      end else if (cnt_b < bsz) begin
        mat_b[cnt_b] = it.element_value;
        cnt_b++;
      end
      if (cnt_a < asz || cnt_b < bsz) return;
      orow = (m == MODE_TRN) ? c : r;
      ocol = (m == MODE_TRN) ? r : (m == MODE_MUL) ? cb : c;
      for (int i = 0; i < orow; i++) begin
        for (int j = 0; j < ocol; j++) begin
          case (m)
            MODE_ADD: acc = 64'(mat_a[i*c+j]) + 64'(mat_b[i*c+j]);
            MODE_SUB: acc = 64'(mat_a[i*c+j]) - 64'(mat_b[i*c+j]);
            MODE_SCALE: acc = fix_mul(mat_a[i*c+j], scale_r);
            MODE_MUL: begin
              acc = 0;
              for (int k = 0; k < c; k++) acc += fix_mul(mat_a[i*c+k], mat_b[k*cb+j]);
            end
            default: acc = 64'(mat_a[j*c+i]);
          endcase
          o.overflow = 1'b0;
          if (acc > 64'sd2147483647) begin
            acc = 64'sd2147483647;
            o.overflow = 1'b1;
          end else if (acc < -64'sd2147483648) begin
            acc = -64'sd2147483648;
            o.overflow = 1'b1;
          end
          o.result_value = acc[31:0];
          o.result_row = i[2:0];
          o.result_col = j[2:0];
          o.last_result = (i == orow - 1 && j == ocol - 1);
          pending.push_back(o);
        end
      end
      cnt_a = 0;
      cnt_b = 0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_o;
      if (pending.size() == 0) begin
        $display("%t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp_o = pending.pop_front();
      if (got.result_value !== exp_o.result_value) begin
        $display("%t: value exp %h got %h", $realtime, exp_o.result_value, got.result_value);
        errors++;
      end
      if (got.result_row !== exp_o.result_row) begin
        $display("%t: row exp %0d got %0d", $realtime, exp_o.result_row, got.result_row);
        errors++;
      end
      if (got.result_col !== exp_o.result_col) begin
        $display("%t: col exp %0d got %0d", $realtime, exp_o.result_col, got.result_col);
        errors++;
      end
      if (got.overflow !== exp_o.overflow) begin
        $display("%t: overflow exp %b got %b", $realtime, exp_o.overflow, got.overflow);
        errors++;
      end
      if (got.last_result !== exp_o.last_result) begin
        $display("%t: last exp %b got %b", $realtime, exp_o.last_result, got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, push, full, empty, pop, psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  in_item_t in_item_i;
  out_item_t out_item_o;

  matrix_arithmetic_engine dut (.*);

  matrix_scoreboard sb;
  int send_idle, recv_idle;
  bit hold_recv;
  int loads_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end

  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_OP_MODE: sb.mode_r = val[2:0];
      REG_ROWS_A: sb.rows_r = val[3:0];
      REG_COLS_A: sb.cols_r = val[3:0];
      REG_COLS_B: sb.colsb_r = val[3:0];
      default: sb.scale_r = val;
    endcase
  endtask

  task automatic set_shape(logic [2:0] m, logic [3:0] r, logic [3:0] c, logic [3:0] cb,
                           logic [31:0] s);
    reg_write(REG_OP_MODE, 32'(m));
    reg_write(REG_ROWS_A, 32'(r));
    reg_write(REG_COLS_A, 32'(c));
    reg_write(REG_COLS_B, 32'(cb));
    reg_write(REG_SCALE, s);
  endtask

  // Lowers push, waits until every expected result is out, then idles before the next job.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  // push stays high after an accepted item; an idle gap or drain() lowers it.
  task automatic send_load(logic kind, logic [31:0] v);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
      while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= '{req_type: kind, element_value: v};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_load('{req_type: kind, element_value: v});
    loads_sent++;
  endtask

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(65536 * 4) - 65536 * 2;
      default: return $urandom;
    endcase
  endfunction

  // Loads the operands a job needs, with a stray load now and then.
  task automatic run_job();
    int unsigned m, r, c, cb, na, nb;
    m = sb.mode_r > 4 ? 4 : sb.mode_r;
    r = sb.dim(sb.rows_r);
    c = sb.dim(sb.cols_r);
    cb = sb.dim(sb.colsb_r);
    na = r * c;
    nb = (m <= 1) ? r * c : (m == 3) ? c * cb : 0;
    while (na + nb > 0) begin
      if (nb > 0 && (na == 0 || $urandom_range(1))) begin
        send_load(1'b1, rand_elem());
        nb--;
      end else begin
        send_load(1'b0, rand_elem());
        na--;
      end
      if ($urandom_range(30) == 0) send_load(m == 2 || m == 4 ? 1'b1 : 1'b0, $urandom);
    end
    // Loads into a full operand after the job are ignored only when a new job is not
    // already filling, so none are sent here.
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_item_i = '0;
    send_idle = 32;
    recv_idle = 49;
    hold_recv = 1'b0;
    loads_sent = 0;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every mode, extreme dimensions and saturating values.
    set_shape(MODE_ADD, 1, 1, 1, 32'h10000);
    send_load(1'b0, 32'h7fffffff);
    send_load(1'b0, 32'h1);
    send_load(1'b1, 32'h7fffffff);
    drain();
    reg_write(REG_OP_MODE, 32'(MODE_SUB));
    send_load(1'b0, 32'h80000000);
    send_load(1'b1, 32'h1);
    drain();
    set_shape(MODE_SCALE, 0, 2, 0, 32'h80000000);
    send_load(1'b1, 32'h5);
    send_load(1'b0, 32'h80000000);
    send_load(1'b0, 32'hffffffff);
    drain();
    set_shape(MODE_TRN, 2, 3, 1, 32'h7fffffff);
    repeat (6) send_load(1'b0, rand_elem());
    drain();
    set_shape(3'd7, 15, 1, 15, 32'h10000);
    repeat (8) send_load(1'b0, $urandom);
    drain();
    set_shape(MODE_MUL, 1, 2, 1, 32'h0);
    send_load(1'b0, 32'h7fffffff);
    send_load(1'b0, 32'h7fffffff);
    send_load(1'b1, 32'h7fffffff);
    send_load(1'b1, 32'h7fffffff);
    drain();

    // Random jobs, mostly small; the idling pattern changes by phase.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 32 : ph == 1 ? 49 : 0;
      recv_idle = ph == 0 ? 49 : ph == 1 ? 32 : 0;
      while (loads_sent < 20 + 35 * (ph + 1) || (ph == 1 && !hold_recv)) begin
        if ($urandom_range(9) == 0)
          set_shape(3'($urandom_range(7)), 4'($urandom_range(15)),
                    4'($urandom_range(15)), 4'($urandom_range(15)), $urandom);
        else
          set_shape(3'($urandom_range(4)), 4'($urandom_range(1, 3)),
                    4'($urandom_range(1, 3)), 4'($urandom_range(1, 3)), rand_elem());
        if (ph == 1 && !hold_recv) begin
          reg_write(REG_OP_MODE, 32'(MODE_TRN));
          hold_recv = 1'b1;
          repeat (3) begin
            run_job();
            push <= 1'b0;
            @(posedge clk_i);
          end
        end else begin
          run_job();
        end
        drain();
      end
    end
    set_shape(MODE_MUL, 8, 8, 8, 32'h10000);
    run_job();
    drain();
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Receiver: random pops, plus one long hold-off to fill the block.
  initial begin
    int stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_result(out_item_o);
      if (hold_recv && stall < 400) begin
        stall++;
        pop <= 1'b0;
      end else begin
        pop <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
      end
    end
  end
endmodule

// ===== matrix_arithmetic_engine.f =====
sv/mae_pkg.sv
sv/mae_jobq.sv
sv/mae_front.sv
sv/mae_back.sv
sv/matrix_arithmetic_engine.sv
dv/testbench.sv
